/* rtl/qas_pkg.sv */
// shared types, constants and arithmetic helpers for the acceleration step core
`timescale 1ns / 1ps
package qas_pkg;

    localparam int TRIG_ITERATIONS = 16;
    localparam int CORDIC_STEPS    = (TRIG_ITERATIONS < 24) ? TRIG_ITERATIONS : 24;

    localparam int ANG_W  = 16;
    localparam int DATA_W = 32;
    localparam int TRIG_W = 34;   // cordic x, y and z working width

    localparam logic signed [ANG_W-1:0]  ANG_PI      = 16'sd25736;
    localparam logic signed [ANG_W-1:0]  ANG_HALF_PI = 16'sd12868;
    localparam logic signed [TRIG_W-1:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic signed [DATA_W:0]   GRAVITY_Q16 = 33'sd642908;
    localparam logic [48:0]              SCALE_LIMIT = 49'h1_0000_0000_0000 >> 1;

    // register indexes
    typedef enum logic [2:0] {
        REG_INV_MASS  = 3'd0,
        REG_INV_IX    = 3'd1,
        REG_INV_IY    = 3'd2,
        REG_ARM       = 3'd3,
        REG_WIND      = 3'd4,
        REG_WIND_DIR  = 3'd5
    } reg_index_t;

    // arctangent table, Q3.29
    function automatic logic signed [TRIG_W-1:0] atan_q29(input int i);
        logic signed [TRIG_W-1:0] v;
        begin
            case (i)
                0:  v = 34'sd421657428;
                1:  v = 34'sd248918915;
                2:  v = 34'sd131521918;
                3:  v = 34'sd66762579;
                4:  v = 34'sd33510843;
                5:  v = 34'sd16771758;
                6:  v = 34'sd8387925;
                7:  v = 34'sd4194219;
                8:  v = 34'sd2097141;
                9:  v = 34'sd1048575;
                default: v = 34'sd1 <<< (29 - i);
            endcase
            return v;
        end
    endfunction

    // signed value times Q1.30 trig, magnitude rounded half away from zero
    // operands never exceed about 2^32 in magnitude, so 35 bits of magnitude suffice
    function automatic logic signed [48:0] mul_trig(input logic signed [48:0] a,
                                                   input logic signed [TRIG_W-1:0] t);
        logic [34:0] ma;
        logic [31:0] mt;
        logic [79:0] p;
        logic [49:0] m;
        begin
            ma = a[48] ? 35'(-a) : a[34:0];
            mt = t[TRIG_W-1] ? 32'(-t) : t[31:0];
            p  = ma * mt;
            m  = 50'((p + 80'(1 << 29)) >> 30);
            return (a[48] ^ t[TRIG_W-1]) ? -49'(m) : 49'(m);
        end
    endfunction

    // magnitude clamp to 2^47 and apply sign
    function automatic logic signed [48:0] clamp_sign(input logic neg, input logic [80:0] r);
        logic [48:0] m;
        begin
            m = (r > 81'(SCALE_LIMIT)) ? SCALE_LIMIT : r[48:0];
            return neg ? -$signed(m) : $signed(m);
        end
    endfunction

    // saturate to signed 32 bit
    function automatic logic signed [DATA_W-1:0] sat_out(input logic signed [49:0] v);
        begin
            if (v > 50'sd2147483647)
                return 32'sh7FFF_FFFF;
            else if (v < -50'sd2147483648)
                return 32'sh8000_0000;
            return v[31:0];
        end
    endfunction

    typedef struct packed {
        logic signed [31:0] force_front;
        logic signed [31:0] force_back;
        logic signed [31:0] force_left;
        logic signed [31:0] force_right;
        logic signed [31:0] torque_front;
        logic signed [31:0] torque_back;
        logic signed [15:0] pitch_angle;
        logic signed [15:0] roll_angle;
        logic signed [15:0] yaw_angle;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] accel_longitudinal;
        logic signed [31:0] accel_lateral;
        logic signed [31:0] accel_vertical;
        logic signed [31:0] accel_pitch;
        logic signed [31:0] accel_roll;
        logic signed [31:0] accel_yaw;
    } out_item_t;

endpackage

/* rtl/qas_stream_if.sv */
// valid/ready channel carrying one payload struct
`timescale 1ns / 1ps
interface qas_in_if;
    logic                valid;
    logic                ready;
    qas_pkg::in_item_t   data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface qas_out_if;
    logic                valid;
    logic                ready;
    qas_pkg::out_item_t  data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* rtl/qas_cordic.sv */
// pipelined rotation-mode cordic, one micro-rotation per stage
`timescale 1ns / 1ps
module qas_cordic (
    input  logic                                  clk,
    input  logic                                  en,
    input  logic signed [qas_pkg::ANG_W-1:0]      angle,
    output logic signed [qas_pkg::TRIG_W-1:0]     sin_out,
    output logic signed [qas_pkg::TRIG_W-1:0]     cos_out
);
    localparam int N = qas_pkg::CORDIC_STEPS;
    localparam int W = qas_pkg::TRIG_W;

    logic signed [W-1:0] x_reg [0:N];
    logic signed [W-1:0] y_reg [0:N];
    logic signed [W-1:0] z_reg [0:N];
    logic                flip_reg [0:N];

    logic signed [qas_pkg::ANG_W:0] ang_fold;
    logic                           flip_next;

    // fold into plus or minus pi/2
    always_comb
    begin
        ang_fold  = 17'(angle);
        flip_next = 1'b0;
        if (angle > qas_pkg::ANG_HALF_PI)
        begin
            ang_fold  = 17'(angle) - 17'(qas_pkg::ANG_PI);
            flip_next = 1'b1;
        end
        else if (angle < -qas_pkg::ANG_HALF_PI)
        begin
            ang_fold  = 17'(angle) + 17'(qas_pkg::ANG_PI);
            flip_next = 1'b1;
        end
    end

    // angle register and micro-rotation stages
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0]    <= qas_pkg::CORDIC_GAIN;
            y_reg[0]    <= '0;
            z_reg[0]    <= W'(ang_fold) <<< 16;
            flip_reg[0] <= flip_next;
            for (int i = 0; i < N; i++)
            begin
                flip_reg[i+1] <= flip_reg[i];
                if (!z_reg[i][W-1])
                begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - qas_pkg::atan_q29(i);
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + qas_pkg::atan_q29(i);
                end
            end
        end
    end

    assign sin_out = flip_reg[N] ? -y_reg[N] : y_reg[N];
    assign cos_out = flip_reg[N] ? -x_reg[N] : x_reg[N];
endmodule

/* rtl/quadrotor_acceleration_step_core.sv */
// top level: stateless acceleration datapath for a quadrotor model
`timescale 1ns / 1ps
// Usage:
//   in_ch  carries one request of four rotor forces, two torques and three
//   angles; out_ch returns one result of six saturated Q16.16 accelerations.
//   The user must write configuration via cfg_we / cfg_index / cfg_data only while idle, unchecked by the core.
// Pipeline: from accept to result valid a request passes the angle register and
//   the cordic micro-rotation stages, then four multiply, scale and saturate
//   stages and the output register.
// Throughput: one request per cycle while in_ch.ready is high. The whole pipeline
//   advances together on a single enable; in_ch.ready is high while the last
//   stage or output register is free, or while out_ch.ready takes the output register.
// Reset: valid bits clear, registers return to their reset values.
// Receiver stall: the pipeline holds in place once its last stage and the
//   output register are full, and in_ch.ready drops; nothing is lost or repeated.
module quadrotor_acceleration_step_core (
    input  logic                         clk,
    input  logic                         rst_n,
    qas_in_if.sink                       in_ch,
    qas_out_if.source                    out_ch,
    input  logic                         cfg_we,
    input  logic [2:0]                   cfg_index,
    input  logic [31:0]                  cfg_data
);
    localparam int CL  = qas_pkg::CORDIC_STEPS + 1;
    localparam int LAT = CL + 4;

    // configuration registers
    logic [31:0]        inv_mass_reg, inv_ix_reg, inv_iy_reg, arm_reg;
    logic signed [31:0] wind_reg;
    logic signed [15:0] wind_dir_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inv_mass_reg <= 32'd65536;
            inv_ix_reg   <= 32'd65536;
            inv_iy_reg   <= 32'd65536;
            arm_reg      <= 32'd16384;
            wind_reg     <= '0;
            wind_dir_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (qas_pkg::reg_index_t'(cfg_index))
                qas_pkg::REG_INV_MASS: inv_mass_reg <= cfg_data;
                qas_pkg::REG_INV_IX:   inv_ix_reg   <= cfg_data;
                qas_pkg::REG_INV_IY:   inv_iy_reg   <= cfg_data;
                qas_pkg::REG_ARM:      arm_reg      <= cfg_data;
                qas_pkg::REG_WIND:     wind_reg     <= cfg_data;
                qas_pkg::REG_WIND_DIR: wind_dir_reg <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // pipeline control and output register
    logic [LAT-1:0]      vld_reg;
    logic                en;
    logic                skid_vld_reg;
    qas_pkg::out_item_t  skid_reg, res_next;

    assign en           = !vld_reg[LAT-1] || !skid_vld_reg || out_ch.ready;
    assign in_ch.ready  = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[LAT-2:0], in_ch.valid};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            skid_vld_reg <= 1'b0;
        else if (en && vld_reg[LAT-1])
            skid_vld_reg <= 1'b1;
        else if (out_ch.ready)
            skid_vld_reg <= 1'b0;
    end

    // last stage moves in whenever the pipeline advances with a valid last stage
    always_ff @(posedge clk)
    begin
        if (en && vld_reg[LAT-1])
            skid_reg <= res_next;
    end

    assign out_ch.valid = skid_vld_reg;
    assign out_ch.data  = skid_reg;

    // trig units
    logic signed [33:0] sp, cp, sr, cr, sy, cy, sd, cd;
    qas_cordic u_pitch (.clk, .en, .angle(in_ch.data.pitch_angle),
                        .sin_out(sp), .cos_out(cp));
    qas_cordic u_roll  (.clk, .en, .angle(in_ch.data.roll_angle),
                        .sin_out(sr), .cos_out(cr));
    qas_cordic u_yaw   (.clk, .en, .angle(in_ch.data.yaw_angle),
                        .sin_out(sy), .cos_out(cy));
    qas_cordic u_wind  (.clk, .en, .angle(wind_dir_reg),
                        .sin_out(sd), .cos_out(cd));

    // force sums, differences and the yaw term delayed alongside the cordic
    logic signed [32:0] fb_reg [0:CL-1];
    logic signed [32:0] lr_reg [0:CL-1];
    logic signed [32:0] dp_reg [0:CL-1];
    logic signed [32:0] dr_reg [0:CL-1];
    logic signed [33:0] yw_reg [0:CL-1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            fb_reg[0] <= 33'(in_ch.data.force_front) + 33'(in_ch.data.force_back);
            lr_reg[0] <= 33'(in_ch.data.force_left) + 33'(in_ch.data.force_right);
            dp_reg[0] <= 33'(in_ch.data.force_front) - 33'(in_ch.data.force_back);
            dr_reg[0] <= 33'(in_ch.data.force_left) - 33'(in_ch.data.force_right);
            yw_reg[0] <= 34'(in_ch.data.torque_front) + 34'(in_ch.data.torque_back)
                       - 34'(in_ch.data.force_right) - 34'(in_ch.data.force_left);
            for (int i = 1; i < CL; i++)
            begin
                fb_reg[i] <= fb_reg[i-1];
                lr_reg[i] <= lr_reg[i-1];
                dp_reg[i] <= dp_reg[i-1];
                dr_reg[i] <= dr_reg[i-1];
                yw_reg[i] <= yw_reg[i-1];
            end
        end
    end

    // register scaling: clamp 2^47, times unsigned q16.16, round, clamp
    function automatic logic signed [48:0] scale(input logic signed [49:0] v,
                                                input logic [31:0] f);
        logic [49:0] mv;
        logic [47:0] m;
        logic [80:0] r;
        begin
            mv = v[49] ? 50'(-v) : 50'(v);
            m  = (mv > 50'(qas_pkg::SCALE_LIMIT)) ? 48'(qas_pkg::SCALE_LIMIT) : mv[47:0];
            r  = 81'(64'(m) * 64'(f[31:16]))
               + 81'((64'(m) * 64'(f[15:0]) + 64'd32768) >> 16);
            return qas_pkg::clamp_sign(v[49], r);
        end
    endfunction

    // stage a: first trig products, wind terms and arm scaling
    logic signed [48:0] a_fbsp, a_lrsr, a_lrnsr, a_fbcp, a_lrcr, a_wcd, a_wsd;
    logic signed [48:0] a_pit, a_rol, a_yaw;
    logic signed [33:0] a_cy, a_sy;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_fbsp  <= qas_pkg::mul_trig(49'(fb_reg[CL-1]), -sp);
            a_lrsr  <= qas_pkg::mul_trig(49'(lr_reg[CL-1]), sr);
            a_lrnsr <= qas_pkg::mul_trig(49'(lr_reg[CL-1]), -sr);
            a_fbcp  <= qas_pkg::mul_trig(49'(fb_reg[CL-1]), cp);
            a_lrcr  <= qas_pkg::mul_trig(49'(lr_reg[CL-1]), cr);
            a_wcd   <= qas_pkg::mul_trig(49'(wind_reg), cd);
            a_wsd   <= qas_pkg::mul_trig(49'(wind_reg), sd);
            a_cy    <= cy;
            a_sy    <= sy;
            a_pit   <= scale(50'(dp_reg[CL-1]), arm_reg);
            a_rol   <= scale(50'(dr_reg[CL-1]), arm_reg);
            a_yaw   <= 49'(yw_reg[CL-1]);
        end
    end

    // stage b: second trig products and sums
    logic signed [49:0] b_lon, b_lat, b_ver;
    logic signed [48:0] b_pit, b_rol, b_yaw;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b_lon <= 50'(qas_pkg::mul_trig(a_fbsp, a_cy)) + 50'(qas_pkg::mul_trig(a_lrsr, a_sy))
                   + 50'(a_wcd);
            b_lat <= 50'(qas_pkg::mul_trig(a_lrnsr, a_cy)) + 50'(qas_pkg::mul_trig(a_fbsp, a_sy))
                   + 50'(a_wsd);
            b_ver <= 50'(a_fbcp) + 50'(a_lrcr) + 50'(a_wsd);
            b_pit <= a_pit;
            b_rol <= a_rol;
            b_yaw <= a_yaw;
        end
    end

    // stage c: scale by mass and inertias
    logic signed [48:0] c_lon, c_lat, c_ver, c_pit, c_rol, c_yaw;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c_lon <= scale(b_lon, inv_mass_reg);
            c_lat <= scale(b_lat, inv_mass_reg);
            c_ver <= scale(b_ver, inv_mass_reg);
            c_pit <= scale(50'(b_pit), inv_iy_reg);
            c_rol <= scale(50'(b_rol), inv_ix_reg);
            c_yaw <= scale(50'(b_yaw), inv_ix_reg);
        end
    end

    // stage d: gravity and saturation
    qas_pkg::out_item_t d_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_reg.accel_longitudinal <= qas_pkg::sat_out(50'(c_lon));
            d_reg.accel_lateral      <= qas_pkg::sat_out(50'(c_lat));
            d_reg.accel_vertical     <= qas_pkg::sat_out(50'(c_ver) - 50'(qas_pkg::GRAVITY_Q16));
            d_reg.accel_pitch        <= qas_pkg::sat_out(50'(c_pit));
            d_reg.accel_roll         <= qas_pkg::sat_out(50'(c_rol));
            d_reg.accel_yaw          <= qas_pkg::sat_out(50'(c_yaw));
        end
    end

    assign res_next = d_reg;
endmodule

/* rtl/qas_checker.sv */
// port-level checker for the acceleration step core, bound to the top level
`timescale 1ns / 1ps
module qas_checker (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready
);
    // a stalled result stays offered
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    // result valid rises only from low
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !$past(out_valid))
        else $error("result valid glitch");

    // input is ready whenever output is drained
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("stall without pending result");
endmodule

bind quadrotor_acceleration_step_core qas_checker u_qas_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready)
);

/* tb/sv/quadrotor_acceleration_step_core_tb.sv */
// testbench for the quadrotor acceleration step core: directed table, random requests, predictor
`timescale 1ns / 1ps
module quadrotor_acceleration_step_core_tb;

    localparam int LATENCY     = 21;
    localparam int CYCLE_LIMIT = 400000;
    localparam int N_RANDOM    = 1100;
    localparam int N_DIRECTED  = 14;
    localparam logic signed [63:0] Q_GRAVITY = 64'sd642908;
    localparam logic signed [63:0] Q_LIMIT   = 64'sd140737488355328;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [2:0] cfg_index;
    logic [31:0] cfg_data;

    qas_in_if  in_ch ();
    qas_out_if out_ch ();

    quadrotor_acceleration_step_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch.sink),
        .out_ch    (out_ch.source),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // predictor copy of the configuration
    logic [31:0] m_inv_mass;
    logic [31:0] m_inv_ix;
    logic [31:0] m_inv_iy;
    logic [31:0] m_arm;
    logic signed [31:0] m_wind;
    logic signed [15:0] m_wind_dir;

    qas_pkg::out_item_t accel_queue[$];
    int errors;
    int cycles;
    logic hold_off;
    int hold_cycles;
    bit sending_done;

    typedef struct {
        qas_pkg::in_item_t   req;
        bit                  has_exp;
        qas_pkg::out_item_t  exp;
    } vector_t;
    vector_t vectors[N_DIRECTED];

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic logic signed [63:0] shr_floor(input logic signed [63:0] v, input int s);
        return v >>> s;
    endfunction

    // rotation-mode cordic with quadrant fold
    task automatic sin_cos(input logic signed [15:0] angle, output logic signed [63:0] s,
                           output logic signed [63:0] c);
        logic signed [63:0] a;
        logic signed [63:0] x;
        logic signed [63:0] y;
        logic signed [63:0] z;
        logic signed [63:0] dx;
        logic signed [63:0] dy;
        logic signed [63:0] at;
        bit flip;
        a = angle;
        flip = 0;
        x = 64'sd652032874;
        y = 0;
        if (a > 12868)
        begin
            a = a - 25736;
            flip = 1;
        end
        else if (a < -12868)
        begin
            a = a + 25736;
            flip = 1;
        end
        z = a * 65536;
        for (int i = 0; i < qas_pkg::TRIG_ITERATIONS && i < 24; i++)
        begin
            case (i)
                0: at = 421657428;
                1: at = 248918915;
                2: at = 131521918;
                3: at = 66762579;
                4: at = 33510843;
                5: at = 16771758;
                6: at = 8387925;
                7: at = 4194219;
                8: at = 2097141;
                9: at = 1048575;
                default: at = 64'sd1 <<< (29 - i);
            endcase
            dx = shr_floor(y, i);
            dy = shr_floor(x, i);
            if (z >= 0)
            begin
                x = x - dx;
                y = y + dy;
                z = z - at;
            end
            else
            begin
                x = x + dx;
                y = y - dy;
                z = z + at;
            end
        end
        s = flip ? -y : y;
        c = flip ? -x : x;
    endtask

    // force times Q1.30 trig, magnitude rounded half away from zero
    function automatic logic signed [63:0] times_trig(input logic signed [63:0] a,
                                                      input logic signed [63:0] t);
        logic [127:0] m;
        logic [63:0] ma;
        logic [63:0] mt;
        ma = a < 0 ? -a : a;
        mt = t < 0 ? -t : t;
        m = (128'(ma) * 128'(mt) + (128'd1 << 29)) >> 30;
        return ((a < 0) != (t < 0)) ? -$signed(64'(m)) : $signed(64'(m));
    endfunction

    // value times unsigned Q16.16 register with 2^47 clamp
    function automatic logic signed [63:0] times_reg(input logic signed [63:0] v,
                                                     input logic [31:0] f);
        logic [127:0] m;
        logic [127:0] r;
        m = v < 0 ? -v : v;
        if (m > Q_LIMIT)
            m = Q_LIMIT;
        r = m * f[31:16] + ((m * f[15:0] + 32768) >> 16);
        if (r > Q_LIMIT)
            r = Q_LIMIT;
        return v < 0 ? -$signed(64'(r)) : $signed(64'(r));
    endfunction

    function automatic logic signed [31:0] clip32(input logic signed [63:0] v);
        if (v > 64'sd2147483647)
            return 32'sh7FFF_FFFF;
        if (v < -64'sd2147483648)
            return 32'sh8000_0000;
        return v[31:0];
    endfunction

    task automatic predict_accel(input qas_pkg::in_item_t r, output qas_pkg::out_item_t o);
        logic signed [63:0] sp, cp, sr, cr, sy, cy, sd, cd;
        logic signed [63:0] fb, lr, lon, lat, ver, w;
        sin_cos(r.pitch_angle, sp, cp);
        sin_cos(r.roll_angle, sr, cr);
        sin_cos(r.yaw_angle, sy, cy);
        sin_cos(m_wind_dir, sd, cd);
        w  = m_wind;
        fb = 64'(r.force_front) + 64'(r.force_back);
        lr = 64'(r.force_left) + 64'(r.force_right);
        lon = times_trig(times_trig(fb, -sp), cy) + times_trig(times_trig(lr, sr), sy)
            + times_trig(w, cd);
        lat = times_trig(times_trig(lr, -sr), cy) + times_trig(times_trig(fb, -sp), sy)
            + times_trig(w, sd);
        ver = times_trig(fb, cp) + times_trig(lr, cr) + times_trig(w, sd);
        o.accel_longitudinal = clip32(times_reg(lon, m_inv_mass));
        o.accel_lateral      = clip32(times_reg(lat, m_inv_mass));
        o.accel_vertical     = clip32(times_reg(ver, m_inv_mass) - Q_GRAVITY);
        o.accel_pitch = clip32(times_reg(times_reg(64'(r.force_front) - 64'(r.force_back),
                                                   m_arm), m_inv_iy));
        o.accel_roll  = clip32(times_reg(times_reg(64'(r.force_left) - 64'(r.force_right),
                                                   m_arm), m_inv_ix));
        o.accel_yaw   = clip32(times_reg(64'(r.torque_front) + 64'(r.torque_back)
                                         - 64'(r.force_right) - 64'(r.force_left), m_inv_ix));
    endtask

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        errors++;
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
    endtask

    task automatic write_reg(input qas_pkg::reg_index_t idx, input logic [31:0] value);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            qas_pkg::REG_INV_MASS: m_inv_mass = value;
            qas_pkg::REG_INV_IX:   m_inv_ix = value;
            qas_pkg::REG_INV_IY:   m_inv_iy = value;
            qas_pkg::REG_ARM:      m_arm = value;
            qas_pkg::REG_WIND:     m_wind = value;
            qas_pkg::REG_WIND_DIR: m_wind_dir = value[15:0];
            default: ;
        endcase
    endtask

    // stop offering and wait until every expected result has come
    task automatic drain();
        in_ch.valid <= 1'b0;
        while (accel_queue.size() != 0)
            @(negedge clk);
        repeat (LATENCY + 4) @(negedge clk);
    endtask

    // send one request after a random gap; expectation is queued at acceptance
    task automatic send_request(input qas_pkg::in_item_t r, input bit has_exp,
                                input qas_pkg::out_item_t exp_in);
        qas_pkg::out_item_t p;
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
        if (gap != 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data <= r;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        if (has_exp)
            p = exp_in;
        else
            predict_accel(r, p);
        accel_queue.push_back(p);
        @(negedge clk);
    endtask

    function automatic logic signed [15:0] rand_angle();
        case ($urandom_range(0, 5))
            0: return 16'($urandom);
            1: return 16'sd25736;
            2: return -16'sd25736;
            default: return 16'($signed($urandom_range(0, 51472)) - 25736);
        endcase
    endfunction

    function automatic logic signed [31:0] rand_force();
        case ($urandom_range(0, 7))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return $urandom;
            default: return 32'($signed($urandom_range(0, 2000000)) - 1000000);
        endcase
    endfunction

    function automatic qas_pkg::in_item_t rand_request();
        qas_pkg::in_item_t r;
        r.force_front = rand_force();
        r.force_back = rand_force();
        r.force_left = rand_force();
        r.force_right = rand_force();
        r.torque_front = rand_force();
        r.torque_back = rand_force();
        r.pitch_angle = rand_angle();
        r.roll_angle = rand_angle();
        r.yaw_angle = rand_angle();
        return r;
    endfunction

    // directed rows; expected values only where obvious
    task automatic fill_vectors();
        qas_pkg::in_item_t z;
        qas_pkg::out_item_t e;
        z = '0;
        foreach (vectors[i])
        begin
            vectors[i].req = z;
            vectors[i].has_exp = 0;
            vectors[i].exp = '0;
        end
        // all zero: only gravity remains
        e = '0;
        e.accel_vertical = -32'sd642908;
        vectors[0].has_exp = 1;
        vectors[0].exp = e;
        // front thrust only, level
        vectors[1].req.force_front = 32'sd65536;
        // full positive forces saturate
        vectors[2].req = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                           32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'sd0, 16'sd0, 16'sd0};
        vectors[3].req = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                           32'h8000_0000, 32'h8000_0000, 16'sd25736, -16'sd25736, 16'sd12868};
        vectors[4].req = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                           32'sd0, 32'sd0, 16'sh7FFF, 16'sh8000, -16'sd12868};
        vectors[5].req = '{32'sd65536, 32'sd65536, 32'sd65536, 32'sd65536,
                           32'sd0, 32'sd0, 16'sd12868, 16'sd12869, -16'sd12869};
        vectors[6].req = '{32'sd100000, -32'sd3000, 32'sd7, -32'sd9, 32'sd5, -32'sd5,
                           16'sd6434, -16'sd6434, 16'sd25000};
        vectors[7].req = '{32'sd1, 32'sd0, 32'sd0, 32'sd0, 32'sd1, 32'sd0,
                           16'sd1, -16'sd1, 16'sd0};
        vectors[8].req = '{-32'sd1, -32'sd1, -32'sd1, -32'sd1, -32'sd1, -32'sd1,
                           -16'sd1, 16'sd0, 16'sd1};
        vectors[9].req = '{32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA,
                           32'h5555_5555, 32'hAAAA_AAAA, 16'h5555, 16'hAAAA, 16'h5555};
        vectors[10].req = '{32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555,
                            32'hAAAA_AAAA, 32'h5555_5555, 16'hAAAA, 16'h5555, 16'hAAAA};
        vectors[11].req = '{32'sd655360, 32'sd0, 32'sd0, 32'sd655360, 32'sd0, 32'sd0,
                            16'sd25736, 16'sd25736, 16'sd25736};
        vectors[12].req = '{32'sd0, 32'sd655360, 32'sd655360, 32'sd0, 32'sd0, 32'sd0,
                            -16'sd25736, 16'sd0, -16'sd25736};
        // torques only feed yaw
        vectors[13].req.torque_front = 32'sd131072;
        vectors[13].req.torque_back = 32'sd65536;
        e = '0;
        e.accel_vertical = -32'sd642908;
        e.accel_yaw = 32'sd196608;
        vectors[13].has_exp = 1;
        vectors[13].exp = e;
    endtask

    task automatic random_phase(input int count);
        qas_pkg::out_item_t none;
        none = '0;
        for (int i = 0; i < count; i++)
            send_request(rand_request(), 0, none);
    endtask

    // stimulus
    initial
    begin
        errors = 0;
        sending_done = 0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        m_inv_mass = 65536;
        m_inv_ix = 65536;
        m_inv_iy = 65536;
        m_arm = 16384;
        m_wind = 0;
        m_wind_dir = 0;
        fill_vectors();
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        foreach (vectors[i])
            send_request(vectors[i].req, vectors[i].has_exp, vectors[i].exp);
        random_phase(200);
        drain();
        // extreme register settings
        write_reg(qas_pkg::REG_INV_MASS, 32'hFFFF_FFFF);
        write_reg(qas_pkg::REG_INV_IX, 32'd1);
        write_reg(qas_pkg::REG_INV_IY, 32'hFFFF_FFFF);
        write_reg(qas_pkg::REG_ARM, 32'd0);
        write_reg(qas_pkg::REG_WIND, 32'h8000_0000);
        write_reg(qas_pkg::REG_WIND_DIR, 32'h0000_6488);
        random_phase(200);
        drain();
        write_reg(qas_pkg::REG_INV_MASS, 32'd1);
        write_reg(qas_pkg::REG_INV_IX, 32'hFFFF_FFFF);
        write_reg(qas_pkg::REG_INV_IY, 32'd1);
        write_reg(qas_pkg::REG_ARM, 32'hFFFF_FFFF);
        write_reg(qas_pkg::REG_WIND, 32'h7FFF_FFFF);
        write_reg(qas_pkg::REG_WIND_DIR, 32'h0000_9B78);
        random_phase(200);
        drain();
        // random settings
        for (int k = 0; k < 3; k++)
        begin
            write_reg(qas_pkg::REG_INV_MASS, $urandom_range(1, 400000));
            write_reg(qas_pkg::REG_INV_IX, $urandom_range(1, 400000));
            write_reg(qas_pkg::REG_INV_IY, $urandom | 32'd1);
            write_reg(qas_pkg::REG_ARM, $urandom_range(0, 200000));
            write_reg(qas_pkg::REG_WIND, $urandom);
            write_reg(qas_pkg::REG_WIND_DIR, 32'($signed($urandom_range(0, 51472)) - 25736));
            random_phase(170);
            drain();
        end
        sending_done = 1;
    end

    // receiver: random stalls plus one long hold-off
    initial
    begin
        int gap;
        qas_pkg::out_item_t want;
        hold_off = 1'b0;
        hold_cycles = 0;
        out_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_off)
                out_ch.ready <= 1'b0;
            else
            begin
                gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 17);
                if (gap != 0)
                begin
                    out_ch.ready <= 1'b0;
                    repeat (gap) @(negedge clk);
                end
                out_ch.ready <= 1'b1;
            end
            @(posedge clk);
            if (out_ch.valid && out_ch.ready)
            begin
                if (accel_queue.size() == 0)
                    report("result with nothing expected", out_ch.data.accel_longitudinal,
                           32'd0);
                else
                begin
                    want = accel_queue.pop_front();
                    if (out_ch.data.accel_longitudinal != want.accel_longitudinal)
                        report("longitudinal", out_ch.data.accel_longitudinal,
                               want.accel_longitudinal);
                    if (out_ch.data.accel_lateral != want.accel_lateral)
                        report("lateral", out_ch.data.accel_lateral, want.accel_lateral);
                    if (out_ch.data.accel_vertical != want.accel_vertical)
                        report("vertical", out_ch.data.accel_vertical, want.accel_vertical);
                    if (out_ch.data.accel_pitch != want.accel_pitch)
                        report("pitch", out_ch.data.accel_pitch, want.accel_pitch);
                    if (out_ch.data.accel_roll != want.accel_roll)
                        report("roll", out_ch.data.accel_roll, want.accel_roll);
                    if (out_ch.data.accel_yaw != want.accel_yaw)
                        report("yaw", out_ch.data.accel_yaw, want.accel_yaw);
                end
            end
        end
    end

    // long receiver hold-off during the first random phase
    initial
    begin
        @(posedge rst_n);
        repeat (600) @(posedge clk);
        hold_off = 1'b1;
        while (hold_cycles < 300)
        begin
            @(posedge clk);
            hold_cycles++;
        end
        hold_off = 1'b0;
    end

    // end of run and cycle limit
    initial
    begin
        cycles = 0;
        while (!sending_done && cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        if (cycles >= CYCLE_LIMIT)
            $display("quadrotor_acceleration_step_core_tb: errors");
        else
        begin
            if (errors == 0 && accel_queue.size() == 0)
                $display("quadrotor_acceleration_step_core_tb: clean");
            else
                $display("quadrotor_acceleration_step_core_tb: errors");
        end
        $finish;
    end

endmodule
